// ===== rtl/wal_pkg.sv =====
// ----------------------------------------------------------------------------
// wal_pkg
// Shared types and codes of the wildcard access list table.
// ----------------------------------------------------------------------------
package wal_pkg;

   localparam logic [2:0] MODE_CHECK  = 3'd0;
   localparam logic [2:0] MODE_ADD    = 3'd1;
   localparam logic [2:0] MODE_REMOVE = 3'd2;
   localparam logic [2:0] MODE_GET    = 3'd3;
   localparam logic [2:0] MODE_CLEAR  = 3'd4;

   localparam logic [1:0] PRIV_NONE = 2'd0;

   localparam int WC_FABRIC   = 0;
   localparam int WC_NODE     = 1;
   localparam int WC_SUBJECT  = 2;
   localparam int WC_CLUSTER  = 3;
   localparam int WC_ENDPOINT = 4;

   typedef struct packed {
      logic [63:0] subject_id;
      logic [63:0] fabric_id;
      logic [63:0] node_id;
      logic [31:0] cluster_id;
      logic [15:0] endpoint_id;
      logic [4:0]  wildcard_mask;
      logic [1:0]  privilege;
      logic        entry_valid;
   } entry_type;

   // per-cycle control from the sequencer to every cell
   typedef struct packed {
      logic shift;    // rotate the ring by one cell toward cell 0
      logic load;     // write the new entry at the tail cell
      logic drop;     // shift applies only to cells at or above the hole
   } cell_ctrl_type;

endpackage

// ===== rtl/wal_cell.sv =====
// ----------------------------------------------------------------------------
// wal_cell
// One table slot: holds an entry and takes its upper neighbor's on a shift.
// ----------------------------------------------------------------------------
module wal_cell
   import wal_pkg::*;
(
   input  logic          clock,
   input  cell_ctrl_type ctrl,
   input  logic          sel,
   input  logic          move,
   input  entry_type     up_entry,
   input  entry_type     new_entry,
   output entry_type     entry
);

   entry_type entry_ff, entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.load && sel) begin
         entry_in = new_entry;
      end else if (ctrl.shift && move) begin
         entry_in = up_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry = entry_ff;

endmodule

// ===== rtl/wal_match.sv =====
// ----------------------------------------------------------------------------
// wal_match
// Compares the entry at cell 0 with the request and decides a grant.
// ----------------------------------------------------------------------------
module wal_match
   import wal_pkg::*;
(
   input  entry_type  entry,
   input  entry_type  key,
   output logic       grant
);

   logic hit;

   always_comb begin
      hit = (entry.wildcard_mask[WC_FABRIC]   || entry.fabric_id   == key.fabric_id)
         && (entry.wildcard_mask[WC_NODE]     || entry.node_id     == key.node_id)
         && (entry.wildcard_mask[WC_SUBJECT]  || entry.subject_id  == key.subject_id)
         && (entry.wildcard_mask[WC_CLUSTER]  || entry.cluster_id  == key.cluster_id)
         && (entry.wildcard_mask[WC_ENDPOINT] || entry.endpoint_id == key.endpoint_id);
      grant = entry.entry_valid && hit && entry.privilege != PRIV_NONE
         && key.privilege != PRIV_NONE && entry.privilege >= key.privilege;
   end

endmodule

// ===== rtl/wildcard_access_list_table.sv =====
// ----------------------------------------------------------------------------
// wildcard_access_list_table
// Access list table kept in a ring of entry cells with wildcard matching.
// ----------------------------------------------------------------------------
// One request at a time. Entries sit in a ring of MAX_ENTRIES cells; every
// cell passes its entry to its lower neighbor on a shift, cell 0 wrapping to
// the top. Add, get, clear and unused modes go straight to the response.
// An in-range remove makes a single shift in which only the cells at or above
// the index take their upper neighbor. Check rotates the whole ring once past
// the matcher at cell 0 in MAX_ENTRIES shifts, so its worst case is set by
// the ring length. The response holds while rsp_ready stays low. Get reads
// the indexed cell through a mux. Entries at or beyond the count are never
// read.
module wildcard_access_list_table
   import wal_pkg::*;
#(
   parameter int MAX_ENTRIES = 16
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_mode,
   input  logic [3:0]  req_index,
   input  logic [63:0] req_subject_id,
   input  logic [63:0] req_fabric_id,
   input  logic [63:0] req_node_id,
   input  logic [31:0] req_cluster_id,
   input  logic [15:0] req_endpoint_id,
   input  logic [4:0]  req_wildcard_mask,
   input  logic [1:0]  req_privilege,
   input  logic        req_entry_valid,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_ok,
   output logic [4:0]  rsp_entry_count,
   output logic [63:0] rsp_out_subject_id,
   output logic [63:0] rsp_out_fabric_id,
   output logic [63:0] rsp_out_node_id,
   output logic [31:0] rsp_out_cluster_id,
   output logic [15:0] rsp_out_endpoint_id,
   output logic [4:0]  rsp_out_wildcard_mask,
   output logic [1:0]  rsp_out_privilege,
   output logic        rsp_out_entry_valid
);

   localparam int CW = $clog2(MAX_ENTRIES + 1);
   localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_RSP  = 2'd2;

   logic [1:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] step_ff, step_in;
   logic [2:0]    mode_ff, mode_in;
   logic [CW-1:0] hole_ff, hole_in;
   logic          grant_ff, grant_in;
   entry_type     key_ff, key_in;
   logic          ok_ff, ok_in;
   entry_type     out_ff, out_in;

   entry_type     ring [MAX_ENTRIES];
   cell_ctrl_type ctrl;
   logic          grant;
   logic          req_fire;
   logic          in_range;
   entry_type     req_entry;

   assign req_fire  = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign in_range  = {{(CW > 4 ? CW - 4 : 0){1'b0}}, req_index} < count_ff
                      && 32'(req_index) < MAX_ENTRIES;

   assign req_entry = '{req_subject_id, req_fabric_id, req_node_id, req_cluster_id,
                        req_endpoint_id, req_wildcard_mask, req_privilege,
                        req_entry_valid};

   assign ctrl.shift = (state_ff == ST_RUN);
   assign ctrl.load  = req_fire && req_mode == MODE_ADD && 32'(count_ff) < MAX_ENTRIES;
   assign ctrl.drop  = (mode_ff == MODE_REMOVE);

   // remove: a single shift in which cells below the hole hold their entry
   genvar g;
   generate
      for (g = 0; g < MAX_ENTRIES; g++) begin : g_cell
         entry_type up;
         logic      sel;
         if (g == MAX_ENTRIES - 1) begin : g_top
            assign up = ring[0];
         end else begin : g_mid
            assign up = ring[g+1];
         end
         assign sel = (32'(count_ff) == g);
         wal_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .sel       (sel),
            .move      (!ctrl.drop || 32'(hole_ff) <= g),
            .up_entry  (up),
            .new_entry (req_entry),
            .entry     (ring[g])
         );
      end
   endgenerate

   wal_match u_match (
      .entry (ring[0]),
      .key   (key_ff),
      .grant (grant)
   );

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      step_in  = step_ff;
      mode_in  = mode_ff;
      hole_in  = hole_ff;
      grant_in = grant_ff;
      key_in   = key_ff;
      ok_in    = ok_ff;
      out_in   = out_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               mode_in  = req_mode;
               key_in   = req_entry;
               hole_in  = CW'(req_index);
               step_in  = '0;
               grant_in = 1'b0;
               out_in   = '0;
               ok_in    = 1'b0;
               state_in = ST_RSP;
               case (req_mode)
                  MODE_CHECK: begin
                     state_in = ST_RUN;
                  end
                  MODE_ADD: begin
                     if (32'(count_ff) < MAX_ENTRIES) begin
                        count_in = count_ff + 1'b1;
                        ok_in    = 1'b1;
                     end
                  end
                  MODE_REMOVE: begin
                     if (in_range) begin
                        state_in = ST_RUN;
                     end
                  end
                  MODE_GET: begin
                     if (in_range) begin
                        out_in = ring[IW'(req_index)];
                        ok_in  = 1'b1;
                     end
                  end
                  MODE_CLEAR: begin
                     count_in = '0;
                     ok_in    = 1'b1;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_RUN: begin
            if (mode_ff == MODE_CHECK && step_ff < count_ff && grant) begin
               grant_in = 1'b1;
            end
            step_in = step_ff + 1'b1;
            if (mode_ff == MODE_REMOVE || 32'(step_ff) == MAX_ENTRIES - 1) begin
               state_in = ST_RSP;
               if (mode_ff == MODE_CHECK) begin
                  ok_in = grant_in && key_ff.privilege != PRIV_NONE;
               end else begin
                  ok_in    = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         ST_RSP: begin
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      step_ff  <= step_in;
      mode_ff  <= mode_in;
      hole_ff  <= hole_in;
      grant_ff <= grant_in;
      key_ff   <= key_in;
      ok_ff    <= ok_in;
      out_ff   <= out_in;
   end

   assign rsp_valid             = (state_ff == ST_RSP);
   assign rsp_ok                = ok_ff;
   assign rsp_entry_count       = 5'(count_ff);
   assign rsp_out_subject_id    = out_ff.subject_id;
   assign rsp_out_fabric_id     = out_ff.fabric_id;
   assign rsp_out_node_id       = out_ff.node_id;
   assign rsp_out_cluster_id    = out_ff.cluster_id;
   assign rsp_out_endpoint_id   = out_ff.endpoint_id;
   assign rsp_out_wildcard_mask = out_ff.wildcard_mask;
   assign rsp_out_privilege     = out_ff.privilege;
   assign rsp_out_entry_valid   = out_ff.entry_valid;

`ifndef ASSERT_OFF
   a_count_max: assert property (@(posedge clock) disable iff (reset)
      32'(count_ff) <= MAX_ENTRIES)
      else $error("entry count above table size");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> !req_ready && !rsp_valid)
      else $error("ring busy but handshake open");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_ok))
      else $error("response dropped while stalled");
`endif

endmodule
